FILE: rtl/sws_pkg.sv
// Package: types, codes and constants of the stop-and-wait sender.
`timescale 1ns / 1ps
package sws_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int TIMER_BITS  = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1024;
  localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_REPLY = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;
  localparam logic [1:0] ACT_DONE = 2'd3;

  localparam logic SEQ_BASE_BIT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_END  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] file_length;
    logic        reply_ack;
    logic        reply_end;
    logic [15:0] reply_ack_number;
    logic        reply_checksum_ok;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        retransmit;
    logic [1:0]  seq_number;
    logic [31:0] packet_index;
    logic [31:0] byte_offset;
    logic [15:0] payload_length;
  } out_word_t;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [31:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   current_seq_odd;
    logic [LENGTH_BITS-1:0] sent_packets;
    logic [LENGTH_BITS-1:0] bytes_left;
    logic [LENGTH_BITS-1:0] sent_offset;
    logic [15:0]            current_length;
    logic [TIMER_BITS-1:0]  tick_count;
  } state_t;

endpackage

FILE: rtl/sws_core.sv
// Next-state and result logic for one input word of the sender.
`timescale 1ns / 1ps
module sws_core (
  input  sws_pkg::state_t   st,
  input  sws_pkg::cfg_t     cfg,
  input  sws_pkg::in_word_t in_word,
  output sws_pkg::state_t   st_nxt,
  output sws_pkg::out_word_t res
);

  logic [15:0]                     cap;
  logic [sws_pkg::LENGTH_BITS-1:0] bl_new;
  logic [sws_pkg::LENGTH_BITS-1:0] len_ext;
  logic [sws_pkg::LENGTH_BITS-1:0] cap_ext;
  logic [sws_pkg::TIMER_BITS-1:0]  tick_inc;
  logic                            send_new;
  logic                            seq_match;

  assign cap       = (cfg.max_payload == 16'd0) ? 16'd1 : cfg.max_payload;
  assign len_ext   = {{(sws_pkg::LENGTH_BITS-16){1'b0}}, st.current_length};
  assign cap_ext   = {{(sws_pkg::LENGTH_BITS-16){1'b0}}, cap};
  assign tick_inc  = (st.tick_count != '1) ? st.tick_count + 1'b1 : st.tick_count;
  assign seq_match = in_word.reply_ack_number == {14'd0, sws_pkg::SEQ_BASE_BIT,
                                                  st.current_seq_odd};

  always_comb begin
    st_nxt   = st;
    res      = '0;
    send_new = 1'b0;
    bl_new   = st.bytes_left;
    unique case (in_word.mode)
      sws_pkg::MODE_START: begin
        bl_new                 = in_word.file_length[sws_pkg::LENGTH_BITS-1:0];
        st_nxt.sent_packets    = '0;
        st_nxt.sent_offset     = '0;
        st_nxt.current_seq_odd = 1'b0;
        st_nxt.current_length  = '0;
        send_new               = 1'b1;
      end
      sws_pkg::MODE_TICK: begin
        if (st.phase == sws_pkg::PH_DATA || st.phase == sws_pkg::PH_END) begin
          st_nxt.tick_count = tick_inc;
          if (tick_inc >= cfg.timeout_ticks) begin
            st_nxt.tick_count = '0;
            res.retransmit    = 1'b1;
            if (st.phase == sws_pkg::PH_DATA) begin
              res.action         = sws_pkg::ACT_DATA;
              res.seq_number     = {sws_pkg::SEQ_BASE_BIT, st.current_seq_odd};
              res.packet_index   = st.sent_packets;
              res.byte_offset    = st.sent_offset;
              res.payload_length = st.current_length;
            end else begin
              res.action = sws_pkg::ACT_END;
            end
          end
        end
      end
      sws_pkg::MODE_REPLY: begin
        if (st.phase == sws_pkg::PH_DATA) begin
          if (in_word.reply_ack && in_word.reply_checksum_ok && seq_match) begin
            bl_new                 = st.bytes_left - len_ext;
            st_nxt.sent_offset     = st.sent_offset + len_ext;
            st_nxt.sent_packets    = st.sent_packets + 1'b1;
            st_nxt.current_seq_odd = ~st.current_seq_odd;
            send_new               = 1'b1;
          end
        end else if (st.phase == sws_pkg::PH_END) begin
          if (in_word.reply_ack && in_word.reply_end) begin
            st_nxt.tick_count = '0;
            if (in_word.reply_checksum_ok) begin
              st_nxt.phase = sws_pkg::PH_IDLE;
              res.action   = sws_pkg::ACT_DONE;
            end else begin
              res.action     = sws_pkg::ACT_END;
              res.retransmit = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    if (send_new) begin
      st_nxt.tick_count = '0;
      st_nxt.bytes_left = bl_new;
      if (bl_new == '0) begin
        st_nxt.phase = sws_pkg::PH_END;
        res.action   = sws_pkg::ACT_END;
      end else begin
        st_nxt.current_length = (bl_new < cap_ext) ? bl_new[15:0] : cap;
        st_nxt.phase          = sws_pkg::PH_DATA;
        res.action            = sws_pkg::ACT_DATA;
        res.seq_number        = {sws_pkg::SEQ_BASE_BIT, st_nxt.current_seq_odd};
        res.packet_index      = st_nxt.sent_packets;
        res.byte_offset       = st_nxt.sent_offset;
        res.payload_length    = st_nxt.current_length;
      end
    end
  end

endmodule

FILE: rtl/stop_and_wait_sender.sv
// Top level of the stop-and-wait sender: state, configuration and result register.
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_ready   sws_pkg::in_word_t
//   out_     output     out_valid/out_ready sws_pkg::out_word_t
//   cfg_     input      cfg_we              cfg_index, cfg_data
//
// One word in, one word out; the result is registered and appears in the cycle after acceptance.
// A new word is taken every cycle while the result register is empty or drains.
// A stall on out_ready holds the result and drops in_ready until it is taken.
// Reset (rst_n low, synchronous) sets idle phase and the register defaults.
`timescale 1ns / 1ps
module stop_and_wait_sender (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sws_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sws_pkg::out_word_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [sws_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sws_pkg::CFG_DATA_W-1:0]       cfg_data
);

  sws_pkg::state_t    st_r, st_nxt;
  sws_pkg::cfg_t      cfg_r;
  sws_pkg::out_word_t res;
  sws_pkg::out_word_t out_r;
  logic               out_valid_r;
  logic               in_fire;

  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  sws_core u_core (
    .st      (st_r),
    .cfg     (cfg_r),
    .in_word (in_data),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r                <= '0;
      cfg_r.max_payload   <= sws_pkg::MAX_PAYLOAD_RST;
      cfg_r.timeout_ticks <= sws_pkg::TIMEOUT_TICKS_RST;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          sws_pkg::CFG_MAX_PAYLOAD:   cfg_r.max_payload   <= cfg_data[15:0];
          sws_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res;
    end
  end

endmodule

FILE: rtl/sws_checker.sv
// Port checker for the stop-and-wait sender and its bind.
`timescale 1ns / 1ps
module sws_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sws_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped under stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  a_data_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == sws_pkg::ACT_DATA |->
      out_data.seq_number == 2'd2 || out_data.seq_number == 2'd3)
    else $error("data word with bad sequence number");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != sws_pkg::ACT_DATA |->
      out_data.seq_number == '0 && out_data.packet_index == '0 &&
      out_data.byte_offset == '0 && out_data.payload_length == '0)
    else $error("non-data word carries packet fields");

endmodule

bind stop_and_wait_sender sws_checker u_sws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
